### sv/fatca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatca_pkg
// Shared types and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package fatca_pkg;

   localparam int ENTRY_W = 28;
   localparam int TOTAL_W = 13;

   localparam logic [ENTRY_W-1:0] EOC_MARK  = 28'hFFFFFFF;
   localparam logic [ENTRY_W-1:0] EOC_ALLOC = 28'hFFFFFF8;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_ALLOC = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_NO_FREE = 2'd2,
      STAT_LOOP    = 2'd3
   } status_type;

endpackage

### sv/fatca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatca_ram
// Single-port table store with registered read data.
// ----------------------------------------------------------------------------
module fatca_ram #(
   parameter int DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          addr,
   input  logic [fatca_pkg::ENTRY_W-1:0]     wdata,
   output logic [fatca_pkg::ENTRY_W-1:0]     rdata
);

   logic [fatca_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [fatca_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/fat_cluster_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator
// FAT32-style next-cluster table with get, set, alloc and chain free.
//
// A command transfer on the req_ channel carries cmd, cluster and
// entry_value, and each command gives exactly one transfer on the rsp_
// channel with status and result_value. The block takes one command at a
// time and stalls the request side until the result has been staged.
// Alloc scans the table one entry at a time through the single memory
// port, from the lowest cluster up, and gives the lowest free one. Free
// walks the chain link by link. A new command can be accepted in the
// cycle after each result is staged. The cluster limit register bounds
// the valid clusters and is written over the csr_ port.
// After reset the table is cleared one entry per cycle, and no command is
// taken during that sweep. A result is held in the output register while
// the receiver stalls, and the next command is accepted meanwhile.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator #(
   parameter int NUM_CLUSTERS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [fatca_pkg::ENTRY_W-1:0]  req_cluster,
   input  logic [fatca_pkg::ENTRY_W-1:0]  req_entry_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [fatca_pkg::ENTRY_W-1:0]  rsp_result_value,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = $clog2(NUM_CLUSTERS);
   localparam int UW = $clog2(NUM_CLUSTERS + 1);
   localparam int CW = (UW > fatca_pkg::TOTAL_W) ? UW : fatca_pkg::TOTAL_W;
   localparam int EW = fatca_pkg::ENTRY_W;
   localparam logic [CW-1:0] NUM_CW = CW'(NUM_CLUSTERS);
   localparam logic [UW-1:0] NUM_UW = UW'(NUM_CLUSTERS);
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CLUSTERS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_GET,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FREE_CHK,
      S_FREE_RD,
      S_OUT
   } state_type;

   state_type                   state_ff;
   logic [fatca_pkg::TOTAL_W-1:0] total_ff;
   logic [AW-1:0]               scan_k_ff;
   logic [AW-1:0]               cur_idx_ff;
   logic [EW-1:0]               cur_ff;
   logic [UW-1:0]               count_ff;
   fatca_pkg::status_type       res_status_ff;
   logic [EW-1:0]               res_value_ff;
   logic                        rsp_valid_ff;
   fatca_pkg::status_type       rsp_status_ff;
   logic [EW-1:0]               rsp_value_ff;

   logic [CW-1:0]               usable;
   logic [EW-1:0]               chk_operand;
   logic [EW-1:0]               chk_offset;
   logic                        chk_below_two;
   logic                        chk_in_table;
   logic [AW-1:0]               chk_idx;
   logic                        scan_last;
   logic                        out_load;
   logic                        ram_we;
   logic [AW-1:0]               ram_addr;
   logic [EW-1:0]               ram_wdata;
   logic [EW-1:0]               ram_rdata;
   fatca_pkg::cmd_type          cmd;

   assign cmd = fatca_pkg::cmd_type'(req_cmd);

   assign usable = (CW'(total_ff) > NUM_CW) ? NUM_CW : CW'(total_ff);

   // The range check is shared between the request and the chain walk.
   assign chk_operand   = (state_ff == S_IDLE) ? req_cluster : cur_ff;
   assign chk_offset    = chk_operand - EW'(2);
   assign chk_below_two = (chk_operand < EW'(2));
   assign chk_in_table  = !chk_below_two && (chk_offset < EW'(usable));
   assign chk_idx       = chk_offset[AW-1:0];

   assign scan_last = ((CW'(scan_k_ff) + CW'(1)) == usable);

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = scan_k_ff;
      ram_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_IDLE: begin
            ram_addr = chk_idx;
            if (req_valid && (cmd == fatca_pkg::CMD_SET) && chk_in_table) begin
               ram_we    = 1'b1;
               ram_wdata = req_entry_value;
            end
         end
         S_SCAN_CHK: begin
            if (ram_rdata == '0) begin
               ram_we    = 1'b1;
               ram_wdata = fatca_pkg::EOC_ALLOC;
            end
         end
         S_FREE_CHK: begin
            ram_addr = chk_idx;
         end
         S_FREE_RD: begin
            ram_addr = cur_idx_ff;
            ram_we   = 1'b1;
         end
         default: begin
            ram_addr = scan_k_ff;
         end
      endcase
   end

   fatca_ram #(
      .DEPTH(NUM_CLUSTERS)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_k_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (scan_k_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end else begin
                  scan_k_ff <= scan_k_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  case (cmd)
                     fatca_pkg::CMD_GET: begin
                        if (chk_below_two) begin
                           res_status_ff <= fatca_pkg::STAT_OK;
                           res_value_ff  <= fatca_pkg::EOC_MARK;
                           state_ff      <= S_OUT;
                        end else if (chk_in_table) begin
                           state_ff <= S_GET;
                        end else begin
                           res_status_ff <= fatca_pkg::STAT_INVALID;
                           res_value_ff  <= fatca_pkg::EOC_MARK;
                           state_ff      <= S_OUT;
                        end
                     end
                     fatca_pkg::CMD_SET: begin
                        if (chk_in_table) begin
                           res_status_ff <= fatca_pkg::STAT_OK;
                        end else begin
                           res_status_ff <= fatca_pkg::STAT_INVALID;
                        end
                        res_value_ff  <= '0;
                        state_ff      <= S_OUT;
                     end
                     fatca_pkg::CMD_ALLOC: begin
                        scan_k_ff <= '0;
                        if (usable == '0) begin
                           res_status_ff <= fatca_pkg::STAT_NO_FREE;
                           res_value_ff  <= '0;
                           state_ff      <= S_OUT;
                        end else begin
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     default: begin
                        cur_ff   <= req_cluster;
                        count_ff <= '0;
                        state_ff <= S_FREE_CHK;
                     end
                  endcase
               end
            end
            S_GET: begin
               res_status_ff <= fatca_pkg::STAT_OK;
               res_value_ff  <= ram_rdata;
               state_ff      <= S_OUT;
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (ram_rdata == '0) begin
                  res_status_ff <= fatca_pkg::STAT_OK;
                  res_value_ff  <= EW'(scan_k_ff) + EW'(2);
                  state_ff      <= S_OUT;
               end else if (scan_last) begin
                  res_status_ff <= fatca_pkg::STAT_NO_FREE;
                  res_value_ff  <= '0;
                  state_ff      <= S_OUT;
               end else begin
                  scan_k_ff <= scan_k_ff + AW'(1);
                  state_ff  <= S_SCAN_RD;
               end
            end
            S_FREE_CHK: begin
               res_value_ff <= EW'(count_ff);
               if (chk_below_two || (cur_ff >= fatca_pkg::EOC_ALLOC)) begin
                  res_status_ff <= fatca_pkg::STAT_OK;
                  state_ff      <= S_OUT;
               end else if (!chk_in_table) begin
                  res_status_ff <= fatca_pkg::STAT_INVALID;
                  state_ff      <= S_OUT;
               end else if (count_ff >= NUM_UW) begin
                  res_status_ff <= fatca_pkg::STAT_LOOP;
                  state_ff      <= S_OUT;
               end else begin
                  cur_idx_ff <= chk_idx;
                  state_ff   <= S_FREE_RD;
               end
            end
            S_FREE_RD: begin
               cur_ff   <= ram_rdata;
               count_ff <= count_ff + UW'(1);
               state_ff <= S_FREE_CHK;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= fatca_pkg::TOTAL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         total_ff <= csr_pwdata[fatca_pkg::TOTAL_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(total_ff);
   assign csr_pready = 1'b1;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

### tb/fatca_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatca_result_checker
// Predicts and checks every result of the cluster chain allocator.
//
// The checker watches the command, result and register ports. It keeps its
// own copy of the allocation table and of the cluster limit, works out the
// status and result_value of each accepted command and queues them. Each
// result transfer is compared field by field with the oldest queued
// outcome. Register reads are checked against the written value.
// ----------------------------------------------------------------------------
module fatca_result_checker #(
   parameter int         NUM_CLUSTERS = 4096,
   parameter logic [2:0] TOTAL_ADDR   = 3'd0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [fatca_pkg::ENTRY_W-1:0] req_cluster,
   input  logic [fatca_pkg::ENTRY_W-1:0] req_entry_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [fatca_pkg::ENTRY_W-1:0] rsp_result_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic [31:0]                   csr_prdata,
   input  logic                          csr_pready,
   output int                            fail_count,
   output int                            pending_count,
   output int                            checked_count
);

   localparam int EW = fatca_pkg::ENTRY_W;
   localparam int TW = fatca_pkg::TOTAL_W;

   typedef struct packed {
      fatca_pkg::status_type status;
      logic [EW-1:0]         value;
   } outcome_type;

   logic [EW-1:0] fat_shadow [NUM_CLUSTERS];
   logic [TW-1:0] total_shadow;
   outcome_type   pending_outcomes [$];

   function automatic int unsigned usable_clusters();
      if (total_shadow > NUM_CLUSTERS) return NUM_CLUSTERS;
      return total_shadow;
   endfunction

   function automatic bit cluster_valid(input int unsigned c);
      return c >= 2 && (c - 2) < usable_clusters();
   endfunction

   // Applies one command to the table copy and returns the outcome it gives.
   function automatic outcome_type apply_command(input fatca_pkg::cmd_type op,
                                                 input logic [EW-1:0] clu,
                                                 input logic [EW-1:0] val);
      outcome_type res;
      int unsigned cur;
      int unsigned nxt;
      int unsigned cnt;
      int unsigned lim;
      res.status = fatca_pkg::STAT_OK;
      res.value  = '0;
      case (op)
         fatca_pkg::CMD_GET: begin
            if (clu < 2) begin
               res.value = fatca_pkg::EOC_MARK;
            end else if (cluster_valid(clu)) begin
               res.value = fat_shadow[clu - 2];
            end else begin
               res.status = fatca_pkg::STAT_INVALID;
               res.value  = fatca_pkg::EOC_MARK;
            end
         end
         fatca_pkg::CMD_SET: begin
            if (cluster_valid(clu)) fat_shadow[clu - 2] = val;
            else res.status = fatca_pkg::STAT_INVALID;
         end
         fatca_pkg::CMD_ALLOC: begin
            res.status = fatca_pkg::STAT_NO_FREE;
            lim = usable_clusters();
            for (int unsigned k = 0; k < lim; k++) begin
               if (fat_shadow[k] == '0) begin
                  fat_shadow[k] = fatca_pkg::EOC_ALLOC;
                  res.value  = EW'(k + 2);
                  res.status = fatca_pkg::STAT_OK;
                  break;
               end
            end
         end
         default: begin
            cur = clu;
            cnt = 0;
            while (cur >= 2 && cur < fatca_pkg::EOC_ALLOC) begin
               if (!cluster_valid(cur)) begin
                  res.status = fatca_pkg::STAT_INVALID;
                  break;
               end
               if (cnt >= NUM_CLUSTERS) begin
                  res.status = fatca_pkg::STAT_LOOP;
                  break;
               end
               nxt = fat_shadow[cur - 2];
               fat_shadow[cur - 2] = '0;
               cnt++;
               cur = nxt;
            end
            res.value = EW'(cnt);
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int k = 0; k < NUM_CLUSTERS; k++) fat_shadow[k] = '0;
         total_shadow = fatca_pkg::TOTAL_RESET;
         pending_outcomes.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == TOTAL_ADDR) begin
            if (csr_pwrite) begin
               total_shadow = csr_pwdata[TW-1:0];
            end else if (csr_prdata !== {{(32-TW){1'b0}}, total_shadow}) begin
               $error("cluster limit readback mismatch: expected 0x%08h, got 0x%08h",
                      {{(32-TW){1'b0}}, total_shadow}, csr_prdata);
               fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(apply_command(fatca_pkg::cmd_type'(req_cmd),
                                                     req_cluster, req_entry_value));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("result transfer with no command outstanding: %s %0d, %s 0x%07h",
                      "status", rsp_status, "result_value", rsp_result_value);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_result_value !== want.value) begin
                  $error("result_value mismatch: expected 0x%07h, got 0x%07h",
                         want.value, rsp_result_value);
                  fail_count++;
               end
               checked_count++;
            end
         end
      end
      pending_count = pending_outcomes.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the cluster chain allocator.
//
// After reset a short directed run covers the boundaries of each command:
// clusters below two, the last valid cluster, invalid starts and links,
// zero entries, chain loops, an empty table and a full one. Then several
// phases, each under its own cluster limit setting, send chains built from
// set commands and freed again, bursts of allocations and random commands,
// with random gaps on the command side and random stalls on the result
// side. The checker instance predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         NUM_CLUSTERS = 4096;
   localparam int         EW           = fatca_pkg::ENTRY_W;
   localparam int         TW           = fatca_pkg::TOTAL_W;
   localparam logic [2:0] TOTAL_ADDR   = 3'd0;
   localparam longint     CYCLE_LIMIT  = 50_000_000;
   localparam int         PHASE_COUNT  = 9;
   localparam int         PHASE_ITEMS  = 125;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [1:0]    req_cmd;
   logic [EW-1:0] req_cluster;
   logic [EW-1:0] req_entry_value;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [1:0]    rsp_status;
   logic [EW-1:0] rsp_result_value;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   int fail_count;
   int pending_count;
   int checked_count;

   longint        cycle_count = 0;
   int            stall_pct   = 0;
   bit            gaps_on     = 1'b0;
   int            items_sent  = 0;
   int            settings_used = 0;
   int            sent_count [4] = '{0, 0, 0, 0};
   logic [TW-1:0] total_setting = fatca_pkg::TOTAL_RESET;
   logic [TW-1:0] phase_total [PHASE_COUNT];

   fat_cluster_chain_allocator #(
      .NUM_CLUSTERS(NUM_CLUSTERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_cluster(req_cluster),
      .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   fatca_result_checker #(
      .NUM_CLUSTERS(NUM_CLUSTERS),
      .TOTAL_ADDR(TOTAL_ADDR)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_cluster(req_cluster),
      .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
         repeat (hold) @(negedge clock);
      end
   end

   function automatic int unsigned span_now();
      if (total_setting > NUM_CLUSTERS) return NUM_CLUSTERS;
      return total_setting;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [EW-1:0] pick_cluster();
      int unsigned span;
      int          r;
      span = span_now();
      r = $urandom_range(0, 99);
      if (r < 60 && span > 0) return EW'(2 + $urandom_range(0, span - 1));
      if (r < 75) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return EW'(1);
            2: return EW'(span + 1);
            default: return EW'(span + 2);
         endcase
      end
      if (r < 85) return fatca_pkg::EOC_ALLOC - EW'(1) + EW'($urandom_range(0, 8));
      return EW'($urandom);
   endfunction

   function automatic logic [EW-1:0] pick_entry();
      int unsigned span;
      int          r;
      span = span_now();
      r = $urandom_range(0, 99);
      if (r < 40 && span > 0) return EW'(2 + $urandom_range(0, span - 1));
      if (r < 55) begin
         return ($urandom_range(0, 1) == 0) ? fatca_pkg::EOC_ALLOC : fatca_pkg::EOC_MARK;
      end
      if (r < 65) return '0;
      return EW'($urandom);
   endfunction

   task automatic send_cmd(input fatca_pkg::cmd_type op, input logic [EW-1:0] clu,
                           input logic [EW-1:0] val);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= op;
      req_cluster     <= clu;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count[int'(op)]++;
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_total(input logic [TW-1:0] value);
      logic [31:0] word;
      wait_idle();
      word = $urandom;
      word[TW-1:0] = value;
      csr_access(1'b1, TOTAL_ADDR, word);
      csr_access(1'b0, TOTAL_ADDR, '0);
      total_setting = value;
      settings_used++;
   endtask

   // Links random valid clusters into a chain, ends it in one of several
   // ways (end marks, zero, an invalid cluster, or back to its start) and
   // frees it again.
   task automatic build_chain();
      logic [EW-1:0] links [$];
      logic [EW-1:0] tail;
      int unsigned   span;
      int            n;
      span = span_now();
      n = $urandom_range(1, 6);
      repeat (n) links.push_back(EW'(2 + $urandom_range(0, span - 1)));
      for (int i = 0; i + 1 < n; i++) send_cmd(fatca_pkg::CMD_SET, links[i], links[i + 1]);
      case ($urandom_range(0, 9))
         0, 1: tail = fatca_pkg::EOC_ALLOC;
         2, 3: tail = fatca_pkg::EOC_MARK;
         4: tail = '0;
         5: tail = fatca_pkg::EOC_ALLOC + EW'($urandom_range(0, 7));
         6: tail = EW'(span + 2 + $urandom_range(0, 1000));
         7: tail = ($urandom_range(0, 3) == 0) ? links[0] : fatca_pkg::EOC_ALLOC;
         8: tail = EW'($urandom_range(0, 1));
         default: tail = pick_entry();
      endcase
      send_cmd(fatca_pkg::CMD_SET, links[n - 1], tail);
      if ($urandom_range(0, 2) == 0)
         send_cmd(fatca_pkg::CMD_GET, links[$urandom_range(0, n - 1)], EW'($urandom));
      send_cmd(fatca_pkg::CMD_FREE, links[0], EW'($urandom));
   endtask

   task automatic alloc_burst();
      int unsigned span;
      int unsigned low_span;
      span = span_now();
      repeat ($urandom_range(1, 5)) send_cmd(fatca_pkg::CMD_ALLOC, pick_cluster(), pick_entry());
      if (span > 0 && $urandom_range(0, 1) == 0) begin
         low_span = (span < 24) ? span : 24;
         send_cmd(fatca_pkg::CMD_FREE, EW'(2 + $urandom_range(0, low_span - 1)),
                  EW'($urandom));
      end
   endtask

   initial begin
      int start;
      int r;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = fatca_pkg::CMD_GET;
      req_cluster     = '0;
      req_entry_value = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_cmd(fatca_pkg::CMD_GET, '0, '0);
      send_cmd(fatca_pkg::CMD_GET, EW'(1), fatca_pkg::EOC_MARK);
      send_cmd(fatca_pkg::CMD_GET, EW'(NUM_CLUSTERS + 1), '0);
      send_cmd(fatca_pkg::CMD_GET, EW'(NUM_CLUSTERS + 2), '0);
      send_cmd(fatca_pkg::CMD_GET, fatca_pkg::EOC_MARK, '0);
      send_cmd(fatca_pkg::CMD_SET, EW'(1), EW'(5));
      send_cmd(fatca_pkg::CMD_SET, EW'(NUM_CLUSTERS + 2), EW'(5));
      send_cmd(fatca_pkg::CMD_SET, EW'(NUM_CLUSTERS + 1), fatca_pkg::EOC_MARK);
      send_cmd(fatca_pkg::CMD_GET, EW'(NUM_CLUSTERS + 1), '0);
      send_cmd(fatca_pkg::CMD_ALLOC, '0, '0);
      send_cmd(fatca_pkg::CMD_ALLOC, fatca_pkg::EOC_MARK, fatca_pkg::EOC_MARK);
      send_cmd(fatca_pkg::CMD_SET, EW'(2), EW'(3));
      send_cmd(fatca_pkg::CMD_FREE, EW'(2), '0);
      send_cmd(fatca_pkg::CMD_FREE, '0, '0);
      send_cmd(fatca_pkg::CMD_FREE, fatca_pkg::EOC_ALLOC, '0);
      send_cmd(fatca_pkg::CMD_FREE, fatca_pkg::EOC_ALLOC - EW'(1), '0);
      send_cmd(fatca_pkg::CMD_FREE, EW'(10), '0);
      send_cmd(fatca_pkg::CMD_SET, EW'(4), EW'(NUM_CLUSTERS + 2));
      send_cmd(fatca_pkg::CMD_FREE, EW'(4), '0);
      send_cmd(fatca_pkg::CMD_SET, EW'(6), EW'(7));
      send_cmd(fatca_pkg::CMD_SET, EW'(7), EW'(6));
      send_cmd(fatca_pkg::CMD_FREE, EW'(6), '0);
      write_total('0);
      send_cmd(fatca_pkg::CMD_GET, EW'(2), '0);
      send_cmd(fatca_pkg::CMD_ALLOC, '0, '0);
      write_total(TW'(1));
      send_cmd(fatca_pkg::CMD_ALLOC, '0, '0);
      send_cmd(fatca_pkg::CMD_ALLOC, '0, '0);

      phase_total = '{TW'(16), TW'(4096), TW'(1), TW'(37),
                      TW'(8191), TW'(64), TW'(0),
                      TW'($urandom_range(2, 300)), TW'(4096)};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_total(phase_total[p]);
         stall_pct = (p % 3) * 30;
         gaps_on   = (p % 4 != 0);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45 && span_now() > 0) build_chain();
            else if (r < 60) alloc_burst();
            else send_cmd(fatca_pkg::cmd_type'($urandom_range(0, 3)), pick_cluster(),
                          pick_entry());
         end
      end

      wait_idle();
      repeat (50) @(negedge clock);
      $display("Sent %0d commands (%0d get, %0d set, %0d alloc, %0d free) under %0d table sizes.",
               items_sent, sent_count[0], sent_count[1], sent_count[2], sent_count[3],
               settings_used);
      $display("Compared %0d result transfers, with chains, loops and full tables.",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### fat_cluster_chain_allocator.f
sv/fatca_pkg.sv
sv/fatca_ram.sv
sv/fat_cluster_chain_allocator.sv
tb/fatca_result_checker.sv
tb/tb_top.sv
